>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertions with synchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

>>> hdl/f2p_pkg.sv
// ----------------------------------------------------------------------------
// f2p_pkg
// Types and constants for the float32 to PCM16 sample converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package f2p_pkg;

    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_PMAX = 2'd1,
        KIND_NMIN = 2'd2,
        KIND_CALC = 2'd3
    } kind_t;

    localparam logic [7:0]  EXP_ONE   = 8'd127;
    localparam logic [7:0]  EXP_TINY  = 8'd110;
    localparam logic [7:0]  EXP_ALL1  = 8'hFF;
    localparam logic [7:0]  SHIFT_OFS = 8'd150;
    localparam logic [15:0] PCM_MAX   = 16'h7FFF;
    localparam logic [15:0] PCM_MIN   = 16'h8000;

endpackage

>>> hdl/float_to_pcm16_sample.sv
// ----------------------------------------------------------------------------
// float_to_pcm16_sample
// Converts a float32 audio sample to signed 16-bit PCM (low/high byte).
// ----------------------------------------------------------------------------
//  channel | dir | tdata
//  s_      | in  | [31:0] sample_bits
//  m_      | out | [7:0] low_byte, [15:8] high_byte
//
//  One item per cycle unless stalled; three stages (decode/multiply, float
//  round, integer round) advance together. m_tready low with m_tvalid high
//  stalls all stages and drops s_tready. Reset clears the valid bits only.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module float_to_pcm16_sample (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] low_byte, [15:8] high_byte
);

    logic ce;

    // stage 1
    logic                s1_valid_reg;
    f2p_pkg::kind_t      s1_kind_reg, s1_kind_next;
    logic                s1_sign_reg;
    logic [38:0]         s1_prod_reg, s1_prod_next;
    logic [5:0]          s1_sh_reg, s1_sh_next;

    // stage 2
    logic                s2_valid_reg;
    f2p_pkg::kind_t      s2_kind_reg;
    logic                s2_sign_reg;
    logic [39:0]         s2_q_reg, s2_q_next;
    logic [5:0]          s2_sh_reg;

    // output
    logic                out_valid_reg;
    logic [15:0]         out_data_reg, out_data_next;

    logic [7:0]  in_exp;
    logic [22:0] in_frac;
    logic [23:0] in_mant;
    logic [7:0]  sh_full;

    logic [24:0] kept;
    logic        round_up;

    logic [40:0] rsum;
    logic [40:0] rmag;
    logic [15:0] mag16;

    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // stage 1: classify, m * 32767
    always_comb begin
        in_exp   = s_tdata[30:23];
        in_frac  = s_tdata[22:0];
        in_mant  = {1'b1, in_frac};
        sh_full  = f2p_pkg::SHIFT_OFS - in_exp;
        s1_sh_next   = sh_full[5:0];
        s1_prod_next = {in_mant, 15'd0} - {15'd0, in_mant};
        if (in_exp == f2p_pkg::EXP_ALL1 && in_frac != 23'd0) begin
            s1_kind_next = f2p_pkg::KIND_ZERO;
        end else if (in_exp >= f2p_pkg::EXP_ONE) begin
            s1_kind_next = s_tdata[31] ? f2p_pkg::KIND_NMIN : f2p_pkg::KIND_PMAX;
        end else if (in_exp < f2p_pkg::EXP_TINY) begin
            s1_kind_next = f2p_pkg::KIND_ZERO;
        end else begin
            s1_kind_next = f2p_pkg::KIND_CALC;
        end
    end

    // stage 2: round product to 24 significant bits, nearest even
    always_comb begin
        if (s1_prod_reg[38]) begin
            round_up = (s1_prod_reg[14:0] > 15'h4000) ||
                       (s1_prod_reg[14:0] == 15'h4000 && s1_prod_reg[15]);
            kept     = {1'b0, s1_prod_reg[38:15]} + {24'd0, round_up};
            s2_q_next = {kept, 15'd0};
        end else begin
            round_up = (s1_prod_reg[13:0] > 14'h2000) ||
                       (s1_prod_reg[13:0] == 14'h2000 && s1_prod_reg[14]);
            kept     = {1'b0, s1_prod_reg[37:14]} + {24'd0, round_up};
            s2_q_next = {1'b0, kept, 14'd0};
        end
    end

    // stage 3: round half away from zero, apply sign
    always_comb begin
        rsum  = {1'b0, s2_q_reg} + (41'd1 << 6'(s2_sh_reg - 6'd1));
        rmag  = rsum >> s2_sh_reg;
        mag16 = {1'b0, rmag[14:0]};
        case (s2_kind_reg)
            f2p_pkg::KIND_PMAX: out_data_next = f2p_pkg::PCM_MAX;
            f2p_pkg::KIND_NMIN: out_data_next = f2p_pkg::PCM_MIN;
            f2p_pkg::KIND_CALC: out_data_next = s2_sign_reg ? (16'd0 - mag16) : mag16;
            default:            out_data_next = 16'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            s1_valid_reg  <= s_tvalid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_kind_reg  <= s1_kind_next;
            s1_sign_reg  <= s_tdata[31];
            s1_prod_reg  <= s1_prod_next;
            s1_sh_reg    <= s1_sh_next;
            s2_kind_reg  <= s1_kind_reg;
            s2_sign_reg  <= s1_sign_reg;
            s2_q_reg     <= s2_q_next;
            s2_sh_reg    <= s1_sh_reg;
            out_data_reg <= out_data_next;
        end
    end

    `ASSERT_CLK(a_ready_when_empty, aclk, aresetn, !out_valid_reg |-> s_tready)
    `ASSERT_NEXT(a_s1_to_s2, aclk, aresetn, ce && s1_valid_reg, s2_valid_reg)
    `ASSERT_NEXT(a_s2_to_out, aclk, aresetn, ce && s2_valid_reg, out_valid_reg)

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for float_to_pcm16_sample. Directed float32 corner patterns, then
// random samples weighted toward the (-1, 1) range, are streamed in with
// random idle bursts on both sides and one long receiver hold-off. Every
// result is checked byte by byte against a bit-exact integer model of the
// float32 scale and the half-away-from-zero rounding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    logic [31:0] sample_q[$];
    logic [15:0] pcm_expected[$];
    int          s_gap = 0;
    int          m_gap = 0;
    int          hold_cnt = 0;
    logic        hold_done = 1'b0;
    int          mismatches = 0;
    int          cycles = 0;
    logic        quiet;

    assign quiet = sample_q.size() < 80;

    float_to_pcm16_sample u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] sample_bits
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [7:0] low_byte, [15:8] high_byte
    );

    // float32 * 32767 with RNE, then round half away from zero, done in integers
    function automatic logic [15:0] pcm_from_float(input logic [31:0] b);
        logic        sgn;
        logic [7:0]  ex;
        logic [22:0] fr;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] mag;
        int          msb;
        int          sh;
        int          t;
        int          e;
        sgn = b[31];
        ex  = b[30:23];
        fr  = b[22:0];
        if (ex == f2p_pkg::EXP_ALL1 && fr != 0)
            return 16'h0000;
        if (ex >= f2p_pkg::EXP_ONE)
            return sgn ? f2p_pkg::PCM_MIN : f2p_pkg::PCM_MAX;
        if (ex == 0) begin
            p = {41'd0, fr};
            e = 1;
        end else begin
            p = {40'd0, 1'b1, fr};
            e = ex;
        end
        p = p * 64'd32767;
        if (p == 0)
            return 16'h0000;
        msb = 0;
        for (int i = 0; i < 64; i++)
            if (p[i])
                msb = i;
        sh = msb - 23;
        q  = p;
        if (sh > 0) begin
            q    = p >> sh;
            rem  = p & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 64'd1;
        end else begin
            sh = 0;
        end
        t = sh + e - 150;
        if (t >= 0)
            mag = q << t;
        else if (-t > 40)
            mag = 0;
        else
            mag = (q >> (-t)) + ((q >> (-t - 1)) & 64'd1);
        if (mag > 64'd32767)
            mag = 64'd32767;
        return sgn ? (~mag[15:0] + 16'd1) : mag[15:0];
    endfunction

    initial begin
        forever #2 aclk = ~aclk;
    end

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_gap    <= 0;
        end else begin
            if (s_tvalid && s_tready)
                pcm_expected = {pcm_expected, pcm_from_float(s_tdata)};
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_gap    <= s_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    if (!quiet && $urandom_range(0, 9) == 0) begin
                        s_gap    <= $urandom_range(0, 8);
                        s_tvalid <= 1'b0;
                    end else begin
                        s_tvalid <= 1'b1;
                        s_tdata  <= sample_q.pop_front();
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off partway through
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            m_gap     <= 0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && sample_q.size() < 400) begin
            if (hold_cnt == 300) begin
                hold_done <= 1'b1;
                m_tready  <= 1'b1;
            end else begin
                hold_cnt <= hold_cnt + 1;
                m_tready <= 1'b0;
            end
        end else if (m_gap > 0) begin
            m_gap    <= m_gap - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_gap    <= $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result check
    always @(posedge aclk) begin
        logic [15:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pcm_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected item %h", m_tdata);
            end else begin
                want = pcm_expected.pop_front();
                if (m_tdata[7:0] !== want[7:0] || m_tdata[15:8] !== want[15:8]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: low/high exp %h/%h got %h/%h", want[7:0],
                                 want[15:8], m_tdata[7:0], m_tdata[15:8]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == 200000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [31:0] r;
        sample_q = '{32'h00000000, 32'h80000000, 32'h3F800000, 32'hBF800000,
                     32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'hFFFFFFFF,
                     32'h7F800001, 32'hFFC00001, 32'h00000001, 32'h807FFFFF,
                     32'h3F000000, 32'hBF000000, 32'h3F7FFFFF, 32'hBF7FFFFF,
                     32'h38000000, 32'h37800000, 32'hB7800000, 32'h40000000,
                     32'hC0000000, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h3F800001,
                     32'h2AAAAAAA};
        for (int n = 0; n < 650; n++) begin
            r = $urandom;
            if ($urandom_range(0, 3) != 0)
                r[30:23] = 8'($urandom_range(100, 126));
            sample_q = {sample_q, r};
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk);
        while (sample_q.size() != 0 || s_tvalid || pcm_expected.size() != 0);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && pcm_expected.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
